// ===== design/vptb_pkg.sv =====
// Shared types and constants of the virtual periodic timer bank.
package vptb_pkg;

   // Request codes carried in req_type.
   localparam logic [2:0] REQ_TICK  = 3'd0;
   localparam logic [2:0] REQ_OPEN  = 3'd1;
   localparam logic [2:0] REQ_RATE  = 3'd2;
   localparam logic [2:0] REQ_ARM   = 3'd3;
   localparam logic [2:0] REQ_CLOSE = 3'd4;

   // Status codes returned with every result.
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_BAD_RATE = 2'd1;
   localparam logic [1:0] STAT_FULL     = 2'd2;
   localparam logic [1:0] STAT_NOT_OPEN = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_SLICE_LENGTH = 1'b0;
   localparam logic CSR_OPEN_PERIOD  = 1'b1;

   // Field widths.
   localparam int unsigned SLICE_W  = 4;
   localparam int unsigned PERIOD_W = 10;
   localparam int unsigned MASK_W   = 16;
   localparam int unsigned RATE_W   = 32;
   localparam int unsigned CSR_W    = 10;

   // Reset values of the configuration registers.
   localparam logic [SLICE_W-1:0]  SLICE_LENGTH_RST = 4'd8;
   localparam logic [PERIOD_W-1:0] OPEN_PERIOD_RST  = 10'd512;

   // Required length of the rate argument in bytes.
   localparam logic [7:0] RATE_ARG_BYTES = 8'd4;

   // One entry of the channel memory.
   typedef struct packed {
      logic [PERIOD_W-1:0] reload;
      logic [PERIOD_W-1:0] count;
   } chan_entry_type;

endpackage

// ===== design/vptb_req_if.sv =====
// Request channel of the virtual periodic timer bank.
interface vptb_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [3:0]  channel;
   logic [31:0] rate_value;
   logic [7:0]  byte_count;
   logic [2:0]  active_mask;
   logic [1:0]  current_terminal;

   modport source (
      output valid, req_type, channel, rate_value, byte_count, active_mask,
             current_terminal,
      input  ready
   );
   modport sink (
      input  valid, req_type, channel, rate_value, byte_count, active_mask,
             current_terminal,
      output ready
   );
endinterface

// ===== design/vptb_rsp_if.sv =====
// Response channel of the virtual periodic timer bank.
interface vptb_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [3:0]  granted_channel;
   logic [15:0] expired_mask;
   logic        switch_valid;
   logic [1:0]  switch_terminal;

   modport source (
      output valid, status, granted_channel, expired_mask, switch_valid,
             switch_terminal,
      input  ready
   );
   modport sink (
      input  valid, status, granted_channel, expired_mask, switch_valid,
             switch_terminal,
      output ready
   );
endinterface

// ===== design/virtual_periodic_timer_bank_top.sv =====
// Virtual periodic timer bank: top level with channel memory and sequencer.
//
// Requests arrive on req_bus and each one yields exactly one response beat
// on rsp_bus. Open, set rate, close and unknown requests finish in the
// cycle they are accepted; the response is valid on the next cycle. An arm
// request reads the channel memory and then writes it back. A tick walks
// the channel memory one entry a cycle, reading one entry while the
// previous one is written back, and loads the response with the write-back
// of the last entry. The single read and write port pair of the channel
// memory sets this order of steps.
// A new request is taken while the last response still waits, provided
// that response leaves in the same cycle; otherwise req_bus.ready is low
// until rsp_bus.ready is seen. A stalled receiver therefore holds back the
// request side but never loses a beat.
// Reset clears the open flags, slice counter and round-robin pointer and
// loads the configuration registers with their reset values. Closed
// channels read as zero, so the channel memory needs no clearing pass and
// the block is ready at once. The user writes configuration through csr_we,
// csr_index and csr_wdata while no request is in flight; the block does not check.
module virtual_periodic_timer_bank_top #(
   parameter int unsigned CHANNELS  = 16,
   parameter int unsigned TERMINALS = 3,
   parameter int unsigned BASE_HZ   = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   vptb_req_if.sink               req_bus,
   vptb_rsp_if.source             rsp_bus,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [vptb_pkg::CSR_W-1:0] csr_wdata
);
   import vptb_pkg::*;

   localparam int unsigned CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int unsigned RR_W  = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
   localparam int unsigned EXP_W = (CHANNELS > MASK_W) ? CHANNELS : MASK_W;
   localparam int unsigned EXT_W = 7;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SWEEP = 3'b010,
      ST_ARM   = 3'b100
   } state_type;

   // Registers.
   state_type             state_ff, state_in;
   logic [CH_W-1:0]       wb_idx_ff, wb_idx_in;
   logic [CHANNELS-1:0]   open_ff, open_in;
   logic [EXP_W-1:0]      exp_ff, exp_in;
   logic [SLICE_W-1:0]    slice_length_ff;
   logic [PERIOD_W-1:0]   open_period_ff;
   logic [SLICE_W-1:0]    slice_count_ff, slice_count_in;
   logic [RR_W-1:0]       rr_ff, rr_in;
   logic                  swv_ff, swv_in;
   logic [1:0]            swt_ff, swt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [3:0]            rsp_granted_ff, rsp_granted_in;
   logic [MASK_W-1:0]     rsp_mask_ff, rsp_mask_in;
   logic                  rsp_swv_ff, rsp_swv_in;
   logic [1:0]            rsp_swt_ff, rsp_swt_in;

   // Channel memory.
   chan_entry_type        chan_mem [CHANNELS];
   chan_entry_type        rd_data_ff;
   logic                  mem_we;
   logic [CH_W-1:0]       mem_waddr;
   logic [CH_W-1:0]       mem_raddr;
   chan_entry_type        mem_wdata;

   // Request decode.
   logic                  req_ready;
   logic                  req_accept;
   logic [EXT_W-1:0]      ch_ext;
   logic [CH_W-1:0]       ch_idx;
   logic                  usable;
   logic                  pow2;
   logic                  rate_ok;
   logic [3:0]            rate_shift;
   logic [PERIOD_W-1:0]   rate_period;
   logic                  any_free;
   logic [CH_W-1:0]       free_idx;
   logic [SLICE_W-1:0]    sched_slice;
   logic [RR_W-1:0]       sched_rr;
   logic                  sched_valid;
   logic [1:0]            sched_term;
   logic [7:0]            act8;
   logic [PERIOD_W-1:0]   sweep_count;
   logic                  last_entry;

   // Response staging.
   logic                  load_rsp;
   logic [1:0]            res_status;
   logic [3:0]            res_granted;
   logic [MASK_W-1:0]     res_mask;
   logic                  res_swv;
   logic [1:0]            res_swt;

   assign req_ready     = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = req_ready;
   assign req_accept    = req_bus.valid && req_ready;

   // Channel addressed by set rate, arm or close.
   assign ch_ext = EXT_W'(req_bus.channel);
   assign ch_idx = ch_ext[CH_W-1:0];
   assign usable = (ch_ext < EXT_W'(CHANNELS)) && open_ff[ch_idx];

   // Rate argument check and period as a shift of the base frequency.
   assign pow2    = (req_bus.rate_value != '0) &&
                    ((req_bus.rate_value & (req_bus.rate_value - 32'd1)) == '0);
   assign rate_ok = (req_bus.byte_count == RATE_ARG_BYTES) && pow2 &&
                    (req_bus.rate_value >= 32'd2) &&
                    (req_bus.rate_value <= RATE_W'(BASE_HZ));

   always_comb begin
      rate_shift = '0;
      for (int b = 1; b <= 10; b++) begin
         if (req_bus.rate_value[b]) begin
            rate_shift = 4'(b);
         end
      end
   end

   assign rate_period = PERIOD_W'(11'(BASE_HZ) >> rate_shift);

   // Lowest free channel.
   always_comb begin
      any_free = 1'b0;
      free_idx = '0;
      for (int i = CHANNELS - 1; i >= 0; i--) begin
         if (!open_ff[i]) begin
            any_free = 1'b1;
            free_idx = CH_W'(i);
         end
      end
   end

   // Slice counter and round-robin terminal choice for a tick.
   assign act8 = 8'(req_bus.active_mask);

   always_comb begin
      sched_slice = slice_count_ff;
      sched_rr    = rr_ff;
      sched_valid = 1'b0;
      sched_term  = '0;
      if (sched_slice != '0) begin
         sched_slice = sched_slice - 1'b1;
      end
      if (sched_slice == '0) begin
         sched_slice = slice_length_ff;
         for (int k = 0; k < TERMINALS; k++) begin
            if (!sched_valid) begin
               sched_rr = (sched_rr == RR_W'(TERMINALS - 1)) ? '0 : sched_rr + 1'b1;
               if (act8[3'(sched_rr)] && (3'(sched_rr) != 3'(req_bus.current_terminal))) begin
                  sched_valid = 1'b1;
                  sched_term  = 2'(sched_rr);
               end
            end
         end
      end
   end

   // Count seen by the sweep; a closed channel reads as zero.
   assign sweep_count = open_ff[wb_idx_ff] ? rd_data_ff.count : '0;
   assign last_entry  = (wb_idx_ff == CH_W'(CHANNELS - 1));

   // Sequencer and read-modify-write control.
   always_comb begin
      state_in       = state_ff;
      wb_idx_in      = wb_idx_ff;
      open_in        = open_ff;
      exp_in         = exp_ff;
      slice_count_in = slice_count_ff;
      rr_in          = rr_ff;
      swv_in         = swv_ff;
      swt_in         = swt_ff;
      mem_we         = 1'b0;
      mem_waddr      = wb_idx_ff;
      mem_wdata      = '0;
      mem_raddr      = CH_W'(wb_idx_ff + 1'b1);
      load_rsp       = 1'b0;
      res_status     = STAT_OK;
      res_granted    = '0;
      res_mask       = '0;
      res_swv        = 1'b0;
      res_swt        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_bus.req_type)
                  REQ_TICK: begin
                     mem_raddr      = '0;
                     wb_idx_in      = '0;
                     exp_in         = '0;
                     slice_count_in = sched_slice;
                     rr_in          = sched_rr;
                     swv_in         = sched_valid;
                     swt_in         = sched_term;
                     state_in       = ST_SWEEP;
                  end
                  REQ_OPEN: begin
                     load_rsp = 1'b1;
                     if (any_free) begin
                        open_in[free_idx] = 1'b1;
                        mem_we            = 1'b1;
                        mem_waddr         = free_idx;
                        mem_wdata.reload  = open_period_ff;
                        mem_wdata.count   = open_period_ff;
                        res_granted       = 4'(free_idx);
                     end else begin
                        res_status = STAT_FULL;
                     end
                  end
                  REQ_RATE: begin
                     load_rsp = 1'b1;
                     if (!rate_ok) begin
                        res_status = STAT_BAD_RATE;
                     end else if (!usable) begin
                        res_status = STAT_NOT_OPEN;
                     end else begin
                        mem_we           = 1'b1;
                        mem_waddr        = ch_idx;
                        mem_wdata.reload = rate_period;
                        mem_wdata.count  = rate_period;
                     end
                  end
                  REQ_ARM: begin
                     if (!usable) begin
                        load_rsp   = 1'b1;
                        res_status = STAT_NOT_OPEN;
                     end else begin
                        mem_raddr = ch_idx;
                        wb_idx_in = ch_idx;
                        state_in  = ST_ARM;
                     end
                  end
                  REQ_CLOSE: begin
                     load_rsp = 1'b1;
                     if (!usable) begin
                        res_status = STAT_NOT_OPEN;
                     end else begin
                        open_in[ch_idx] = 1'b0;
                     end
                  end
                  default: begin
                     load_rsp = 1'b1;
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            // Write back the entry read last cycle while reading the next.
            mem_we           = 1'b1;
            mem_wdata.reload = rd_data_ff.reload;
            mem_wdata.count  = (sweep_count != '0) ? sweep_count - 1'b1 : '0;
            exp_in[wb_idx_ff] = (sweep_count == PERIOD_W'(1));
            wb_idx_in         = CH_W'(wb_idx_ff + 1'b1);
            if (last_entry) begin
               load_rsp = 1'b1;
               res_mask = exp_in[MASK_W-1:0];
               res_swv  = swv_ff;
               res_swt  = swt_ff;
               state_in = ST_IDLE;
            end
         end
         ST_ARM: begin
            mem_we           = 1'b1;
            mem_wdata.reload = rd_data_ff.reload;
            mem_wdata.count  = rd_data_ff.reload;
            load_rsp         = 1'b1;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_mask_in    = rsp_mask_ff;
      rsp_swv_in     = rsp_swv_ff;
      rsp_swt_in     = rsp_swt_ff;
      if (load_rsp) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = res_status;
         rsp_granted_in = res_granted;
         rsp_mask_in    = res_mask;
         rsp_swv_in     = res_swv;
         rsp_swt_in     = res_swt;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.status          = rsp_status_ff;
   assign rsp_bus.granted_channel = rsp_granted_ff;
   assign rsp_bus.expired_mask    = rsp_mask_ff;
   assign rsp_bus.switch_valid    = rsp_swv_ff;
   assign rsp_bus.switch_terminal = rsp_swt_ff;

   // Channel memory with a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         chan_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= chan_mem[mem_raddr];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         open_ff         <= '0;
         slice_count_ff  <= '0;
         rr_ff           <= '0;
         rsp_valid_ff    <= 1'b0;
         slice_length_ff <= SLICE_LENGTH_RST;
         open_period_ff  <= OPEN_PERIOD_RST;
      end else begin
         state_ff       <= state_in;
         open_ff        <= open_in;
         slice_count_ff <= slice_count_in;
         rr_ff          <= rr_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_SLICE_LENGTH: slice_length_ff <= csr_wdata[SLICE_W-1:0];
               CSR_OPEN_PERIOD:  open_period_ff  <= csr_wdata[PERIOD_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      wb_idx_ff      <= wb_idx_in;
      exp_ff         <= exp_in;
      swv_ff         <= swv_in;
      swt_ff         <= swt_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_mask_ff    <= rsp_mask_in;
      rsp_swv_ff     <= rsp_swv_in;
      rsp_swt_ff     <= rsp_swt_in;
   end

   // A response beat is never pending while a request is in flight.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_valid_ff)
      else $error("response pending during a sweep or arm write-back");

   // A successful open marks the granted channel as open.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_bus.req_type == REQ_OPEN) && any_free) |=>
         open_ff[$past(free_idx)])
      else $error("opened channel not marked open");

   // A switch request is only ever reported with an ok status.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_swv_ff) |-> (rsp_status_ff == STAT_OK))
      else $error("terminal switch reported with an error status");

   // The sweep finishes on the last channel and returns to idle.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SWEEP) && last_entry) |=>
         ((state_ff == ST_IDLE) && rsp_valid_ff))
      else $error("sweep did not end with a response");

   // An arm write-back always returns to idle with an ok response on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ARM) |=> ((state_ff == ST_IDLE) && rsp_valid_ff &&
         (rsp_status_ff == STAT_OK)))
      else $error("arm write-back did not complete");

endmodule

// ===== tb/tb_virtual_periodic_timer_bank_top.sv =====
// Self-checking testbench for the virtual periodic timer bank top level.
module tb_virtual_periodic_timer_bank_top;
   import vptb_pkg::*;

   localparam int unsigned CHANNELS      = 16;
   localparam int unsigned TERMINALS     = 3;
   localparam int unsigned TICK_HZ       = 1024;
   localparam int unsigned HALF_PERIOD   = 5;
   localparam int unsigned IDLE_PERCENT  = 13;
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned PHASE_ITEMS   = 200;
   localparam logic [2:0]  REQ_FIRST_UNUSED = REQ_CLOSE + 3'd1;

   // One request beat and one response beat, at the widths of the channels.
   typedef struct packed {
      logic [2:0]  req_type;
      logic [3:0]  channel;
      logic [31:0] rate_value;
      logic [7:0]  byte_count;
      logic [2:0]  active_mask;
      logic [1:0]  current_terminal;
   } timer_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  granted_channel;
      logic [15:0] expired_mask;
      logic        switch_valid;
      logic [1:0]  switch_terminal;
   } timer_rsp_type;

   // Shadow of the timer bank: it predicts each response on acceptance of the
   // request and holds the predictions until the matching beat comes back.
   class timer_bank_tracker_type;
      bit                  chan_open   [CHANNELS];
      logic [PERIOD_W-1:0] chan_reload [CHANNELS];
      logic [PERIOD_W-1:0] chan_count  [CHANNELS];
      logic [SLICE_W-1:0]  slice_left;
      logic [1:0]          rr_term;
      logic [SLICE_W-1:0]  slice_length;
      logic [PERIOD_W-1:0] open_period;
      timer_rsp_type       awaited_rsps[$];
      int unsigned         errors;
      int unsigned         checked;
      int unsigned         ticks;
      int unsigned         expiries;
      int unsigned         switches;
      int unsigned         status_seen [4];

      function new();
         for (int i = 0; i < CHANNELS; i++) begin
            chan_open[i]   = 1'b0;
            chan_reload[i] = '0;
            chan_count[i]  = '0;
         end
         for (int s = 0; s < 4; s++) begin
            status_seen[s] = 0;
         end
         slice_left   = '0;
         rr_term      = '0;
         slice_length = SLICE_LENGTH_RST;
         open_period  = OPEN_PERIOD_RST;
         errors       = 0;
         checked      = 0;
         ticks        = 0;
         expiries     = 0;
         switches     = 0;
      endfunction

      function void write_reg(logic index, logic [CSR_W-1:0] value);
         if (index == CSR_SLICE_LENGTH) begin
            slice_length = value[SLICE_W-1:0];
         end else begin
            open_period = value[PERIOD_W-1:0];
         end
      endfunction

      // Applies one request to the shadow state and returns its response.
      function timer_rsp_type predict_response(timer_req_type r);
         timer_rsp_type rsp;
         logic          found;
         logic          usable;
         logic          pow2;
         rsp = '0;
         found = 1'b0;
         usable = chan_open[r.channel];
         case (r.req_type)
            REQ_TICK: begin
               ticks++;
               for (int i = 0; i < CHANNELS; i++) begin
                  if (chan_count[i] != 0) begin
                     chan_count[i] = chan_count[i] - 1'b1;
                     if (chan_count[i] == 0) begin
                        rsp.expired_mask[4'(i)] = 1'b1;
                     end
                  end
               end
               if (slice_left != 0) begin
                  slice_left = slice_left - 1'b1;
               end
               // A scheduling decision rotates at most once round all terminals.
               if (slice_left == 0) begin
                  slice_left = slice_length;
                  for (int k = 0; k < TERMINALS; k++) begin
                     if (!found) begin
                        rr_term = (rr_term == TERMINALS - 1) ? 2'd0 : rr_term + 2'd1;
                        if (r.active_mask[rr_term] && rr_term != r.current_terminal) begin
                           found = 1'b1;
                           rsp.switch_valid = 1'b1;
                           rsp.switch_terminal = rr_term;
                        end
                     end
                  end
               end
            end
            REQ_OPEN: begin
               rsp.status = STAT_FULL;
               for (int i = 0; i < CHANNELS; i++) begin
                  if (!found && !chan_open[i]) begin
                     found = 1'b1;
                     chan_open[i] = 1'b1;
                     chan_reload[i] = open_period;
                     chan_count[i] = open_period;
                     rsp.granted_channel = 4'(i);
                     rsp.status = STAT_OK;
                  end
               end
            end
            REQ_RATE: begin
               pow2 = r.rate_value != 0 && (r.rate_value & (r.rate_value - 1)) == 0;
               // The argument is judged before the channel.
               if (r.byte_count != RATE_ARG_BYTES || !pow2 || r.rate_value < 2
                   || r.rate_value > TICK_HZ) begin
                  rsp.status = STAT_BAD_RATE;
               end else if (!usable) begin
                  rsp.status = STAT_NOT_OPEN;
               end else begin
                  chan_reload[r.channel] = PERIOD_W'(TICK_HZ / r.rate_value);
                  chan_count[r.channel] = chan_reload[r.channel];
               end
            end
            REQ_ARM: begin
               if (!usable) begin
                  rsp.status = STAT_NOT_OPEN;
               end else begin
                  chan_count[r.channel] = chan_reload[r.channel];
               end
            end
            REQ_CLOSE: begin
               if (!usable) begin
                  rsp.status = STAT_NOT_OPEN;
               end else begin
                  chan_open[r.channel] = 1'b0;
                  chan_reload[r.channel] = '0;
                  chan_count[r.channel] = '0;
               end
            end
            default: begin
               // Unused request codes leave everything alone.
            end
         endcase
         return rsp;
      endfunction

      function void note_request(timer_req_type r);
         awaited_rsps.push_back(predict_response(r));
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(timer_rsp_type seen);
         timer_rsp_type want;
         if (awaited_rsps.size() == 0) begin
            $error("response beat arrived with no request outstanding");
            errors++;
            return;
         end
         want = awaited_rsps.pop_front();
         checked++;
         status_seen[want.status]++;
         expiries += $countones(want.expired_mask);
         if (want.switch_valid) begin
            switches++;
         end
         compare_field("status", want.status, seen.status);
         compare_field("granted_channel", want.granted_channel, seen.granted_channel);
         compare_field("expired_mask", want.expired_mask, seen.expired_mask);
         compare_field("switch_valid", want.switch_valid, seen.switch_valid);
         compare_field("switch_terminal", want.switch_terminal, seen.switch_terminal);
      endfunction

      function int unsigned outstanding();
         return awaited_rsps.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic                   csr_index;
   logic [CSR_W-1:0]       csr_wdata;
   logic                   steady;
   timer_bank_tracker_type tracker = new();

   vptb_req_if req_bus ();
   vptb_rsp_if rsp_bus ();

   virtual_periodic_timer_bank_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // The receiver stalls at random except during a steady stretch.
   always @(negedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // Every accepted response beat is checked against the oldest prediction.
   always @(posedge clock) begin : response_monitor
      timer_rsp_type seen;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.status          = rsp_bus.status;
         seen.granted_channel = rsp_bus.granted_channel;
         seen.expired_mask    = rsp_bus.expired_mask;
         seen.switch_valid    = rsp_bus.switch_valid;
         seen.switch_terminal = rsp_bus.switch_terminal;
         tracker.check_response(seen);
      end
   end

   // Presents one request beat, with random idle cycles ahead of it, and
   // returns once the block has accepted it.
   task automatic drive_req(input timer_req_type r);
      @(negedge clock);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.req_type         <= r.req_type;
      req_bus.channel          <= r.channel;
      req_bus.rate_value       <= r.rate_value;
      req_bus.byte_count       <= r.byte_count;
      req_bus.active_mask      <= r.active_mask;
      req_bus.current_terminal <= r.current_terminal;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      tracker.note_request(r);
   endtask

   // Lowers valid and waits until every predicted response has come back.
   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (tracker.outstanding() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_csr(input logic index, input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      tracker.write_reg(index, value);
   endtask

   function automatic timer_req_type make_req(logic [2:0] kind, logic [3:0] ch,
                                              logic [31:0] rate, logic [7:0] nbytes,
                                              logic [2:0] active, logic [1:0] cur);
      timer_req_type r;
      r.req_type         = kind;
      r.channel          = ch;
      r.rate_value       = rate;
      r.byte_count       = nbytes;
      r.active_mask      = active;
      r.current_terminal = cur;
      return r;
   endfunction

   // Picks one of the channels now open, or the fallback if none is.
   function automatic logic [3:0] some_open_channel(logic [3:0] fallback);
      logic [3:0] open_list[$];
      for (int i = 0; i < CHANNELS; i++) begin
         if (tracker.chan_open[i]) begin
            open_list.push_back(4'(i));
         end
      end
      if (open_list.size() == 0) begin
         return fallback;
      end
      return open_list[$urandom_range(open_list.size() - 1)];
   endfunction

   // Mostly meaningful requests aimed at open channels, with some noise.
   function automatic timer_req_type random_request();
      timer_req_type r;
      int unsigned   pick;
      int unsigned   sel;
      r = make_req(REQ_TICK, 4'($urandom_range(15)), $urandom, 8'($urandom_range(255)),
                   3'($urandom_range(7)), 2'($urandom_range(3)));
      pick = $urandom_range(99);
      if (pick < 44) begin
         r.req_type = REQ_TICK;
      end else if (pick < 58) begin
         r.req_type = REQ_OPEN;
      end else if (pick < 74) begin
         r.req_type = REQ_RATE;
      end else if (pick < 86) begin
         r.req_type = REQ_ARM;
      end else if (pick < 94) begin
         r.req_type = REQ_CLOSE;
      end else begin
         r.req_type = REQ_FIRST_UNUSED + 3'($urandom_range(2));
      end
      if ((r.req_type == REQ_RATE || r.req_type == REQ_ARM || r.req_type == REQ_CLOSE)
          && $urandom_range(3) != 0) begin
         r.channel = some_open_channel(r.channel);
      end
      // Rate arguments: mostly legal, then out of range, bad length or arbitrary.
      if (r.req_type == REQ_RATE) begin
         sel = $urandom_range(9);
         if (sel < 7) begin
            r.rate_value = 32'd1 << $urandom_range(10, 1);
            r.byte_count = RATE_ARG_BYTES;
         end else if (sel == 7) begin
            r.rate_value = 32'd1 << $urandom_range(31);
            r.byte_count = RATE_ARG_BYTES;
         end else if (sel == 8) begin
            r.rate_value = 32'd1 << $urandom_range(10, 1);
         end
      end
      return r;
   endfunction

   // Reprograms the block while idle, then runs one stretch of random traffic.
   task automatic run_phase(input logic [SLICE_W-1:0] slice, input logic [PERIOD_W-1:0] period,
                            input int unsigned opens_first, input logic calm);
      drain();
      write_csr(CSR_SLICE_LENGTH, CSR_W'(slice));
      write_csr(CSR_OPEN_PERIOD, CSR_W'(period));
      steady = calm;
      for (int n = 0; n < opens_first; n++) begin
         drive_req(make_req(REQ_OPEN, 4'($urandom_range(15)), $urandom,
                            8'($urandom_range(255)), 3'($urandom_range(7)),
                            2'($urandom_range(3))));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         drive_req(random_request());
      end
   endtask

   initial begin
      reset                    = 1'b1;
      steady                   = 1'b0;
      csr_we                   = 1'b0;
      csr_index                = CSR_SLICE_LENGTH;
      csr_wdata                = '0;
      rsp_bus.ready            = 1'b0;
      req_bus.valid            = 1'b0;
      req_bus.req_type         = REQ_TICK;
      req_bus.channel          = '0;
      req_bus.rate_value       = '0;
      req_bus.byte_count       = '0;
      req_bus.active_mask      = '0;
      req_bus.current_terminal = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // First tick decides at once; no active terminal, so no switch.
      drive_req(make_req(REQ_TICK, 4'd0, 32'd0, 8'd0, 3'b000, 2'd3));
      // Unused request codes with every field at its top value.
      drive_req(make_req(REQ_FIRST_UNUSED, 4'd15, '1, '1, 3'b111, 2'd3));
      drive_req(make_req(REQ_FIRST_UNUSED + 3'd1, 4'd15, '1, '1, 3'b111, 2'd3));
      drive_req(make_req(REQ_FIRST_UNUSED + 3'd2, 4'd15, '1, '1, 3'b111, 2'd3));
      // Closed channels: a good rate is refused for the channel, a bad one for the rate.
      drive_req(make_req(REQ_RATE, 4'd0, 32'd64, RATE_ARG_BYTES, 3'b001, 2'd0));
      drive_req(make_req(REQ_RATE, 4'd0, 32'd3, RATE_ARG_BYTES, 3'b001, 2'd0));
      drive_req(make_req(REQ_ARM, 4'd15, 32'd0, 8'd0, 3'b010, 2'd1));
      drive_req(make_req(REQ_CLOSE, 4'd7, 32'd0, 8'd0, 3'b100, 2'd2));
      // Open two channels and give them the fastest and slowest legal rates.
      drive_req(make_req(REQ_OPEN, 4'd9, 32'd0, 8'd0, 3'b011, 2'd0));
      drive_req(make_req(REQ_OPEN, 4'd9, 32'd0, 8'd0, 3'b011, 2'd0));
      drive_req(make_req(REQ_RATE, 4'd0, 32'd1024, RATE_ARG_BYTES, 3'b011, 2'd0));
      drive_req(make_req(REQ_RATE, 4'd1, 32'd2, RATE_ARG_BYTES, 3'b011, 2'd0));
      // Rate arguments just outside the legal set, and a wrong length.
      drive_req(make_req(REQ_RATE, 4'd1, 32'd1, RATE_ARG_BYTES, 3'b011, 2'd0));
      drive_req(make_req(REQ_RATE, 4'd1, 32'd2048, RATE_ARG_BYTES, 3'b011, 2'd0));
      drive_req(make_req(REQ_RATE, 4'd1, 32'd512, 8'hFF, 3'b011, 2'd0));
      drive_req(make_req(REQ_RATE, 4'd1, 32'h8000_0000, RATE_ARG_BYTES, 3'b011, 2'd0));
      // Channel 0, with a period of one, expires on the tick before it is armed and on the tick after.
      drive_req(make_req(REQ_TICK, 4'd0, 32'd0, 8'd0, 3'b111, 2'd0));
      drive_req(make_req(REQ_ARM, 4'd0, 32'd0, 8'd0, 3'b111, 2'd0));
      drive_req(make_req(REQ_TICK, 4'd0, 32'd0, 8'd0, 3'b111, 2'd0));
      // Close a channel, arm it afterwards, then reopen the lowest free one.
      drive_req(make_req(REQ_CLOSE, 4'd1, 32'd0, 8'd0, 3'b000, 2'd3));
      drive_req(make_req(REQ_ARM, 4'd1, 32'd0, 8'd0, 3'b000, 2'd3));
      drive_req(make_req(REQ_OPEN, 4'd0, 32'd0, 8'd0, 3'b000, 2'd3));

      // Random traffic over a range of settings; the zero period phase fills the
      // bank first so that further opens find it full.
      run_phase(4'd1, 10'd3, 0, 1'b0);
      run_phase(4'd0, 10'd0, CHANNELS + 2, 1'b0);
      run_phase(4'd15, 10'd512, 0, 1'b1);
      run_phase(4'd5, 10'd1, 0, 1'b0);
      run_phase(4'd2, 10'd17, 0, 1'b0);
      run_phase(4'd15, 10'd1, 0, 1'b0);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Checked %0d responses: %0d ticks, %0d channel expiries, %0d terminal switches.",
               tracker.checked, tracker.ticks, tracker.expiries, tracker.switches);
      $display("Status counts: ok %0d, bad rate %0d, bank full %0d, not open %0d.",
               tracker.status_seen[STAT_OK], tracker.status_seen[STAT_BAD_RATE],
               tracker.status_seen[STAT_FULL], tracker.status_seen[STAT_NOT_OPEN]);
      if (tracker.errors == 0 && tracker.outstanding() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

// ===== files.f =====
design/vptb_pkg.sv
design/vptb_req_if.sv
design/vptb_rsp_if.sv
design/virtual_periodic_timer_bank_top.sv
tb/tb_virtual_periodic_timer_bank_top.sv
